// ===== rtl/core/rmef_pkg.sv =====
// ----------------------------------------------------------------------------
// rmef_pkg: shared types and constants of the RSSI median/average filter
// Sample type, fixed limits of the validity check, register indexes and the
// status bundle that the guard stage hands back to the top level.
// ----------------------------------------------------------------------------
package rmef_pkg;

  // signed dBm sample as it travels through the filter
  typedef logic signed [7:0] dbm_t;

  // validity check limits and idle output
  localparam dbm_t DBM_IDLE      = -8'sd100;
  localparam dbm_t RAW_POS_LIMIT = 8'sd20;
  localparam dbm_t RAW_INVALID_P = 8'sd127;
  localparam dbm_t RAW_INVALID_N = -8'sd128;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int THR_W      = 7;
  localparam int RUN_W      = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_THRESHOLD  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_ACCEPT_RUN = 1'd1;

  localparam logic [THR_W-1:0] THR_RESET = 7'd12;
  localparam logic [RUN_W-1:0] RUN_RESET = 2'd2;

  // spike guard status for one sample
  typedef struct packed {
    logic             held;
    logic [RUN_W-1:0] run;
  } guard_stat_t;

endpackage

// ===== rtl/core/rmef_median.sv =====
// ----------------------------------------------------------------------------
// rmef_median: rank-based median of the filled window entries
// Every entry gets its rank from pairwise compares (ties broken by slot),
// the middle ranks are picked and averaged with truncation toward zero.
// ----------------------------------------------------------------------------
module rmef_median #(
  parameter int W  = 5,
  parameter int CW = $clog2(W + 1)
) (
  input  rmef_pkg::dbm_t  win [W],
  input  logic [CW-1:0]   cnt,
  output rmef_pkg::dbm_t  med
);
  import rmef_pkg::*;

  logic [CW-1:0]     rank [W];
  logic [CW-1:0]     lo_idx;
  logic [CW-1:0]     hi_idx;
  dbm_t              lo_v;
  dbm_t              hi_v;
  logic signed [8:0] sum;
  logic signed [8:0] adj;

  // rank every filled entry against the others
  always_comb begin
    for (int i = 0; i < W; i++) begin
      rank[i] = '0;
      for (int j = 0; j < W; j++) begin
        rank[i] = rank[i] + CW'((CW'(j) < cnt) &&
                  ((win[j] < win[i]) || ((win[j] == win[i]) && (j < i))));
      end
    end
  end

  // pick the two middle ranks (equal for an odd count)
  assign lo_idx = (cnt - CW'(1)) >> 1;
  assign hi_idx = cnt >> 1;

  always_comb begin
    lo_v = '0;
    hi_v = '0;
    for (int i = 0; i < W; i++) begin
      if ((CW'(i) < cnt) && (rank[i] == lo_idx)) begin
        lo_v = lo_v | win[i];
      end
      if ((CW'(i) < cnt) && (rank[i] == hi_idx)) begin
        hi_v = hi_v | win[i];
      end
    end
  end

  // mean of the middle pair, truncated toward zero
  assign sum = {lo_v[7], lo_v} + {hi_v[7], hi_v};
  assign adj = sum + $signed({8'b0, sum[8]});
  assign med = adj[8:1];

endmodule

// ===== rtl/core/rmef_ema.sv =====
// ----------------------------------------------------------------------------
// rmef_ema: spike guard and exponential average update
// Compares the median with the running average, holds a spike until the
// accept run is reached and, once primed, folds in the chosen v as (7*avg+v)/8.
// ----------------------------------------------------------------------------
module rmef_ema (
  input  rmef_pkg::dbm_t                   med,
  input  rmef_pkg::dbm_t                   avg,
  input  logic                             primed,
  input  logic [rmef_pkg::THR_W-1:0]       thr,
  input  logic [rmef_pkg::RUN_W-1:0]       accept_run,
  input  logic [rmef_pkg::RUN_W-1:0]       run,
  output rmef_pkg::dbm_t                   avg_nxt,
  output rmef_pkg::guard_stat_t            stat
);
  import rmef_pkg::*;

  logic signed [8:0]  diff;
  logic [8:0]         mag;
  logic               spike;
  logic [RUN_W-1:0]   run_inc;
  dbm_t               used;
  logic signed [10:0] avg_x;
  logic signed [10:0] used_x;
  logic signed [10:0] acc;
  logic signed [10:0] acc_adj;

  // distance between median and average
  assign diff  = {med[7], med} - {avg[7], avg};
  assign mag   = diff[8] ? 9'(-diff) : 9'(diff);
  assign spike = primed && (mag >= {2'b0, thr});

  // hold a spike until the run reaches the accept count
  assign run_inc = run + RUN_W'(1);

  always_comb begin
    stat.held = 1'b0;
    stat.run  = '0;
    used      = med;
    if (spike && (run_inc < accept_run)) begin
      stat.held = 1'b1;
      stat.run  = run_inc;
      used      = avg;
    end
  end

  // weighted average, truncated toward zero
  assign avg_x   = {{3{avg[7]}}, avg};
  assign used_x  = {{3{used[7]}}, used};
  assign acc     = (avg_x <<< 3) - avg_x + used_x;
  assign acc_adj = acc + (acc[10] ? 11'sd7 : 11'sd0);
  assign avg_nxt = primed ? acc_adj[10:3] : med;

endmodule

// ===== rtl/core/rssi_median_ema_filter.sv =====
// ----------------------------------------------------------------------------
// rssi_median_ema_filter: median window plus exponential average for RSSI
// Validates raw samples, keeps a ring of the last samples, takes their
// median and tracks a spike-guarded running average.
// ----------------------------------------------------------------------------
// Each accepted input beat gives exactly one result beat. A beat is captured
// in an input register and then goes through the rank network and the
// average update into the result register, which updates the filter state
// in the same edge. One beat is accepted every cycle while the result side
// keeps up; the rate is bounded by the state loop (rank compares, median
// select, spike compare, average add). in_stall rises only while a finished
// result waits and the input register is also full.
// Configuration writes take effect at once and are meant for idle periods.
module rssi_median_ema_filter #(
  parameter int WINDOW_LEN = 5
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  rmef_pkg::dbm_t                     in_raw_rssi,
  input  logic                               in_clear,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output rmef_pkg::dbm_t                     out_filtered_dbm,
  output logic                               out_sample_valid,
  output logic                               out_spike_held,
  // configuration
  input  logic                               cfg_we,
  input  logic [rmef_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rmef_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rmef_pkg::*;

  localparam int SW = $clog2(WINDOW_LEN);
  localparam int CW = $clog2(WINDOW_LEN + 1);

  // configuration registers
  logic [THR_W-1:0]  thr_r;
  logic [RUN_W-1:0]  accept_r;

  // input register
  logic              s1_v_r;
  dbm_t              s1_raw_r;
  logic              s1_clear_r;

  // filter state
  dbm_t              sample_ring_r [WINDOW_LEN];
  logic [SW-1:0]     slot_r;
  logic [CW-1:0]     fill_r;
  dbm_t              avg_r;
  logic              primed_r;
  logic [RUN_W-1:0]  run_r;

  // result register
  logic              out_v_r;
  dbm_t              out_dbm_r;
  logic              out_sv_r;
  logic              out_held_r;

  logic              adv;
  logic              samp_ok;
  dbm_t              samp;
  dbm_t              win [WINDOW_LEN];
  logic [CW-1:0]     fill_nxt;
  logic [SW-1:0]     slot_nxt;
  dbm_t              med;
  dbm_t              avg_nxt;
  guard_stat_t       stat;

  // move the input beat on when the result register is free or draining
  assign adv      = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = s1_v_r && !adv;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= THR_RESET;
      accept_r <= RUN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPIKE_THRESHOLD:  thr_r    <= cfg_data[THR_W-1:0];
        CFG_SPIKE_ACCEPT_RUN: accept_r <= cfg_data[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // capture the input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (!in_stall) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_raw_r   <= in_raw_rssi;
      s1_clear_r <= in_clear;
    end
  end

  // check the sample and fold it to a negative dBm value
  assign samp_ok = !((s1_raw_r == '0) || (s1_raw_r == RAW_INVALID_P) ||
                     (s1_raw_r == RAW_INVALID_N) || (s1_raw_r > RAW_POS_LIMIT));
  assign samp    = (s1_raw_r > 8'sd0) ? -s1_raw_r : s1_raw_r;

  // window as it stands after this sample is written
  always_comb begin
    for (int i = 0; i < WINDOW_LEN; i++) begin
      win[i] = (slot_r == SW'(i)) ? samp : sample_ring_r[i];
    end
  end

  assign fill_nxt = (fill_r == CW'(WINDOW_LEN)) ? fill_r : fill_r + CW'(1);
  assign slot_nxt = (slot_r == SW'(WINDOW_LEN - 1)) ? '0 : slot_r + SW'(1);

  rmef_median #(
    .W  (WINDOW_LEN),
    .CW (CW)
  ) u_median (
    .win (win),
    .cnt (fill_nxt),
    .med (med)
  );

  rmef_ema u_ema (
    .med        (med),
    .avg        (avg_r),
    .primed     (primed_r),
    .thr        (thr_r),
    .accept_run (accept_r),
    .run        (run_r),
    .avg_nxt    (avg_nxt),
    .stat       (stat)
  );

  // write the ring entry
  always_ff @(posedge clk) begin
    for (int i = 0; i < WINDOW_LEN; i++) begin
      if (adv && !s1_clear_r && samp_ok && (slot_r == SW'(i))) begin
        sample_ring_r[i] <= samp;
      end
    end
  end

  // update the filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r   <= '0;
      fill_r   <= '0;
      avg_r    <= DBM_IDLE;
      primed_r <= 1'b0;
      run_r    <= '0;
    end else if (adv) begin
      if (s1_clear_r) begin
        slot_r   <= '0;
        fill_r   <= '0;
        avg_r    <= DBM_IDLE;
        primed_r <= 1'b0;
        run_r    <= '0;
      end else if (samp_ok) begin
        slot_r   <= slot_nxt;
        fill_r   <= fill_nxt;
        avg_r    <= avg_nxt;
        primed_r <= 1'b1;
        run_r    <= stat.run;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s1_clear_r) begin
        out_dbm_r  <= DBM_IDLE;
        out_sv_r   <= 1'b0;
        out_held_r <= 1'b0;
      end else if (samp_ok) begin
        out_dbm_r  <= avg_nxt;
        out_sv_r   <= 1'b1;
        out_held_r <= stat.held;
      end else begin
        out_dbm_r  <= primed_r ? avg_r : DBM_IDLE;
        out_sv_r   <= 1'b0;
        out_held_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_v_r;
  assign out_filtered_dbm = out_dbm_r;
  assign out_sample_valid = out_sv_r;
  assign out_spike_held   = out_held_r;

`ifndef SYNTHESIS
  // fill count and write slot stay inside the window
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r <= CW'(WINDOW_LEN)) && (slot_r <= SW'(WINDOW_LEN - 1)))
    else $error("fill count or write slot out of range");

  // an unprimed average sits at the idle value
  a_idle_avg: assert property (@(posedge clk) disable iff (!rst_n)
    !primed_r |-> (avg_r == DBM_IDLE))
    else $error("average moved while unprimed");

  // a held spike only comes from a used sample
  a_held_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_held_r) |-> out_sv_r)
    else $error("spike held on an unused sample");

  // a clear beat empties the filter
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_clear_r) |=> (!primed_r && (fill_r == '0) && (run_r == '0)))
    else $error("clear did not empty the filter");

  // the input register never drops a beat while the result is stalled
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !adv) |=> s1_v_r)
    else $error("input beat lost");
`endif

endmodule
